@@ rtl/glyph_field_intensity_unit_macros.svh @@
// Assertion macros used by the glyph field intensity top level.
`ifndef GLYPH_FIELD_INTENSITY_UNIT_MACROS_SVH
`define GLYPH_FIELD_INTENSITY_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define GFI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("glyph field intensity check failed");
// Checked on every clock edge, reset included.
`define GFI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("glyph field intensity check failed");
`else
`define GFI_ASSERT(lbl, prop)
`define GFI_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/gfi_pkg.sv @@
// Types, constants and helper functions of the glyph field intensity unit.
`default_nettype none
package gfi_pkg;

  localparam int unsigned NUM_STG = 7;

  localparam logic [1:0] CFG_SEED = 2'd0;
  localparam logic [1:0] CFG_MODE = 2'd1;

  localparam logic signed [30:0] MUL_X = 31'sd374761393;
  localparam logic signed [30:0] MUL_Y = 31'sd668265263;

  // Reciprocals for the two rounding divisions.
  localparam logic [20:0] RECIP_MEAN = 21'd932068;   // ceil(2^24 / 18)
  localparam logic [20:0] RECIP_NORM = 21'd1657009;  // ceil(2^28 / 162)
  localparam logic signed [20:0] OFS_MEAN = 21'sd111609;
  localparam logic signed [20:0] OFS_NORM = 21'sd110673;
  localparam logic [15:0] MEAN_BIAS = 16'd6200;
  localparam logic [12:0] NORM_MAX = 13'd4096;

  typedef struct packed {
    logic [NUM_STG-1:0] adv;
    logic [NUM_STG-1:0] vld;
  } gfi_pipe_t;

  typedef logic signed [5:0] score_t;

  localparam score_t PAIR_MAT [5][5] = '{
    '{ 6'sd8,  -6'sd6,  6'sd2,  6'sd2,  6'sd2},
    '{-6'sd6,   6'sd8,  6'sd2,  6'sd2,  6'sd2},
    '{ 6'sd2,   6'sd2, 6'sd12, 6'sd16, 6'sd20},
    '{ 6'sd2,   6'sd2, 6'sd16,  6'sd6, 6'sd14},
    '{ 6'sd2,   6'sd2, 6'sd20, 6'sd14, 6'sd24}
  };

  // Non-negative residue mod 5 of a two's complement 64-bit value.
  function automatic logic [2:0] mod5_s64(input logic [63:0] v);
    logic [7:0] acc;
    logic [4:0] t;
    logic [4:0] r;
    acc = '0;
    for (int i = 0; i < 16; i++) begin
      acc = acc + {4'b0, v[4*i +: 4]};
    end
    t = {1'b0, acc[7:4]} + {1'b0, acc[3:0]};
    r = {4'b0, t[4]} + {1'b0, t[3:0]};
    if (r >= 5'd10) r = r - 5'd10;
    if (r >= 5'd5) r = r - 5'd5;
    if (v[63]) r = (r == 5'd0) ? 5'd4 : r - 5'd1;
    return r[2:0];
  endfunction

  function automatic score_t pair_score(input logic [2:0] ri, input logic [2:0] mi,
                                        input logic [2:0] rj, input logic [2:0] mj);
    logic [2:0] d;
    d = (mi > mj) ? mi - mj : mj - mi;
    return PAIR_MAT[ri][rj] + score_t'({3'b0, d});
  endfunction

endpackage
`default_nettype wire

@@ rtl/gfi_cell_hash.sv @@
// Cell hash: glyph type, matrix row and magnitude of one cell.
`default_nettype none
module gfi_cell_hash
  import gfi_pkg::*;
(
  input  wire logic [63:0] prod_x_i,
  input  wire logic [63:0] prod_y_i,
  input  wire logic [31:0] seed_i,
  output logic [2:0]       type_o,
  output logic [2:0]       row_o,
  output logic [2:0]       mag_o
);
  logic [63:0] hash;
  logic [63:0] hash_sh;

  assign hash    = prod_x_i ^ prod_y_i ^ {32'b0, seed_i};
  assign hash_sh = {{8{hash[63]}}, hash[63:8]};
  assign type_o  = mod5_s64(hash);
  // Types zero and one swap matrix rows.
  assign row_o   = (type_o < 3'd2) ? (type_o ^ 3'd1) : type_o;
  assign mag_o   = mod5_s64(hash_sh) + 3'd1;
endmodule
`default_nettype wire

@@ rtl/gfi_pipe_ctrl.sv @@
// Valid and advance control for the stages of the intensity pipeline.
`default_nettype none
module gfi_pipe_ctrl
  import gfi_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic out_ready_i,
  output gfi_pipe_t pipe_o
);
  logic [NUM_STG-1:0] vld_q, vld_d, adv;

  always_comb begin
    adv[NUM_STG-1] = !vld_q[NUM_STG-1] || out_ready_i;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
    vld_d[0] = in_valid_i;
    for (int k = 1; k < NUM_STG; k++) begin
      vld_d[k] = vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STG; k++) begin
        if (adv[k]) vld_q[k] <= vld_d[k];
      end
    end
  end

  assign pipe_o.adv = adv;
  assign pipe_o.vld = vld_q;
endmodule
`default_nettype wire

@@ rtl/glyph_field_intensity_unit.sv @@
// Top level of the glyph field intensity unit: a seven-stage pipeline.
//
// Input channel: coord_x_i and coord_y_i arrive with in_valid_i and are
// taken when in_ready_o is high. Each item gives exactly one result on the
// output channel (out_valid_o / out_ready_i): the exact pair score sum in
// quarter units, the intensity in Q.12, and the centre cell's type and
// magnitude.
// An accepted item passes through the stage registers in order, stage 0
// to the output register of stage 6. One item enters per cycle while
// in_ready_o is high; the rate is set by the seven stage registers, each
// of which advances whenever it is empty or the stage after it advances.
// When the receiver stalls, results stack up in the stages behind the
// output register and in_ready_o drops only once every stage holds an item.
// The configuration port (cfg_valid_i, cfg_index_i, cfg_data_i) is always
// ready: index 0 writes the seed, index 1 the normalize mode; other indexes
// are ignored. Write it only while the pipeline is empty.
// Reset clears the pipeline valid bits, the seed and the mode.
`default_nettype none
`include "glyph_field_intensity_unit_macros.svh"
module glyph_field_intensity_unit
  import gfi_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [31:0] coord_x_i,
  input  wire logic signed [31:0] coord_y_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [10:0]      pair_sum_quarters_o,
  output logic signed [15:0]      intensity_q12_o,
  output logic [2:0]              centre_type_o,
  output logic [2:0]              centre_magnitude_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);
  gfi_pipe_t pipe;

  logic [31:0] seed_q;
  logic        mode_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_SEED) seed_q <= cfg_data_i;
      if (cfg_index_i == CFG_MODE) mode_q <= cfg_data_i[0];
    end
  end

  gfi_pipe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_ready_i(out_ready_i),
    .pipe_o     (pipe)
  );

  assign in_ready_o  = pipe.adv[0];
  assign out_valid_o = pipe.vld[NUM_STG-1];

  // Stage 0: the three neighbour columns and rows, wrapping in 32 bits.
  logic signed [31:0] xs_q [3];
  logic signed [31:0] ys_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe.adv[0]) begin
      xs_q[0] <= coord_x_i - 32'sd1;
      xs_q[1] <= coord_x_i;
      xs_q[2] <= coord_x_i + 32'sd1;
      ys_q[0] <= coord_y_i - 32'sd1;
      ys_q[1] <= coord_y_i;
      ys_q[2] <= coord_y_i + 32'sd1;
    end
  end

  // Stage 1: hash products, sign-extended to 64 bits.
  logic [63:0] px_q [3];
  logic [63:0] py_q [3];

  always_ff @(posedge clk_i) begin
    if (pipe.adv[1]) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [62:0] prx;
        logic signed [62:0] pry;
        prx = xs_q[k] * MUL_X;
        pry = ys_q[k] * MUL_Y;
        px_q[k] <= {prx[62], prx};
        py_q[k] <= {pry[62], pry};
      end
    end
  end

  // Stage 2: cell properties for the nine cells, row-major from top left.
  logic [2:0] c_type [9];
  logic [2:0] c_row  [9];
  logic [2:0] c_mag  [9];
  logic [2:0] row_q  [9];
  logic [2:0] mag_q  [9];
  logic [2:0] ctype_q2;

  for (genvar k = 0; k < 9; k++) begin : g_cell
    gfi_cell_hash u_hash (
      .prod_x_i(px_q[k % 3]),
      .prod_y_i(py_q[k / 3]),
      .seed_i  (seed_q),
      .type_o  (c_type[k]),
      .row_o   (c_row[k]),
      .mag_o   (c_mag[k])
    );
  end

  always_ff @(posedge clk_i) begin
    if (pipe.adv[2]) begin
      for (int k = 0; k < 9; k++) begin
        row_q[k] <= c_row[k];
        mag_q[k] <= c_mag[k];
      end
      ctype_q2 <= c_type[4];
    end
  end

  // Stage 3: for each cell, the scores of its pairs with the later cells.
  logic signed [9:0] part_q [9];
  logic [2:0]        ctype_q3;
  logic [2:0]        cmag_q3;

  always_ff @(posedge clk_i) begin
    if (pipe.adv[3]) begin
      for (int i = 0; i < 9; i++) begin
        logic signed [9:0] acc;
        acc = '0;
        for (int j = i + 1; j < 9; j++) begin
          acc = acc + 10'(pair_score(row_q[i], mag_q[i], row_q[j], mag_q[j]));
        end
        part_q[i] <= acc;
      end
      ctype_q3 <= ctype_q2;
      cmag_q3  <= mag_q[4];
    end
  end

  // Stage 4: total pair sum.
  logic signed [10:0] sum_q4;
  logic [2:0]         ctype_q4;
  logic [2:0]         cmag_q4;
  logic signed [11:0] sum_all;

  always_comb begin
    sum_all = '0;
    for (int i = 0; i < 9; i++) begin
      sum_all = sum_all + 12'(part_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe.adv[4]) begin
      sum_q4   <= sum_all[10:0];
      ctype_q4 <= ctype_q3;
      cmag_q4  <= cmag_q3;
    end
  end

  // Stage 5: the rounded quotient as a multiply by a reciprocal. The
  // numerator is offset so that it stays non-negative in either mode.
  logic signed [20:0] numer;
  logic [40:0]        prod_q5;
  logic signed [10:0] sum_q5;
  logic [2:0]         ctype_q5;
  logic [2:0]         cmag_q5;
  logic               mode_q5;

  assign numer = {{1{sum_q4[10]}}, sum_q4, 9'b0} + (mode_q ? OFS_NORM : OFS_MEAN);

  always_ff @(posedge clk_i) begin
    if (pipe.adv[5]) begin
      prod_q5  <= {21'b0, numer[19:0]} * {20'b0, (mode_q ? RECIP_NORM : RECIP_MEAN)};
      sum_q5   <= sum_q4;
      ctype_q5 <= ctype_q4;
      cmag_q5  <= cmag_q4;
      mode_q5  <= mode_q;
    end
  end

  // Stage 6: output register.
  logic [15:0] q_mean;
  logic [12:0] q_norm_raw;
  logic [15:0] q_norm;

  assign q_mean     = prod_q5[39:24] - MEAN_BIAS;
  assign q_norm_raw = prod_q5[40:28];
  assign q_norm     = {3'b0, (q_norm_raw > NORM_MAX) ? NORM_MAX : q_norm_raw};

  always_ff @(posedge clk_i) begin
    if (pipe.adv[6]) begin
      pair_sum_quarters_o <= sum_q5;
      intensity_q12_o     <= mode_q5 ? q_norm : q_mean;
      centre_type_o       <= ctype_q5;
      centre_magnitude_o  <= cmag_q5;
    end
  end

  `GFI_ASSERT(a_full_stall_blocks_input, (&pipe.vld && !out_ready_i) |-> !in_ready_o)
  `GFI_ASSERT(a_mag_range,
              out_valid_o |-> (centre_magnitude_o >= 3'd1 && centre_magnitude_o <= 3'd5))
  `GFI_ASSERT(a_type_range, out_valid_o |-> (centre_type_o <= 3'd4))
  `GFI_ASSERT_ALWAYS(a_reset_empty, !rst_ni |-> !out_valid_o)
endmodule
`default_nettype wire

@@ test/glyph_field_intensity_unit_test.sv @@
// Self-checking testbench of the glyph field intensity unit.
`timescale 1ns / 1ps
`default_nettype none
module glyph_field_intensity_unit_test;
  import gfi_pkg::*;

  // One result of the block, as the scoreboard holds it.
  typedef struct packed {
    logic signed [10:0] pair_sum;
    logic signed [15:0] intensity;
    logic [2:0]         ctype;
    logic [2:0]         cmag;
  } field_result_t;

  // One row of the directed table: a coordinate and, where it can be read
  // off at a glance, the expected centre type and magnitude.
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic               has_expected;
    field_result_t      expected;
  } directed_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic signed [31:0] coord_x_i;
  logic signed [31:0] coord_y_i;
  logic out_valid_o;
  logic out_ready_i;
  logic signed [10:0] pair_sum_quarters_o;
  logic signed [15:0] intensity_q12_o;
  logic [2:0] centre_type_o;
  logic [2:0] centre_magnitude_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  glyph_field_intensity_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .coord_x_i(coord_x_i),
    .coord_y_i(coord_y_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .pair_sum_quarters_o(pair_sum_quarters_o),
    .intensity_q12_o(intensity_q12_o),
    .centre_type_o(centre_type_o),
    .centre_magnitude_o(centre_magnitude_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  // The predictor keeps its own copy of the two registers.
  logic [31:0] model_seed;
  logic        model_normalize;

  field_result_t expected_results[$];
  int unsigned   mismatch_count;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Non-negative remainder mod 5 of a 64-bit two's complement value.
  function automatic int unsigned residue5(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = v % 64'sd5;
    if (r < 0) r = r + 64'sd5;
    return int'(r);
  endfunction

  // Matrix entry in quarter units, indexed by row (not by type code).
  function automatic int interaction_quarters(input int unsigned ri, input int unsigned rj);
    int m [5][5];
    m = '{'{8, -6, 2, 2, 2}, '{-6, 8, 2, 2, 2}, '{2, 2, 12, 16, 20},
          '{2, 2, 16, 6, 14}, '{2, 2, 20, 14, 24}};
    return m[ri][rj];
  endfunction

  // Floor division for a positive divisor.
  function automatic int floor_quot(input int n, input int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  // Computes the field result at one coordinate under the current registers.
  function automatic field_result_t field_at(input logic signed [31:0] x,
                                             input logic signed [31:0] y);
    int unsigned cell_row[9];
    int unsigned cell_mag[9];
    int unsigned cell_type[9];
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [63:0] h;
    int sum;
    int q;
    int d;
    int k;
    field_result_t r;
    k = 0;
    sum = 0;
    for (int dy = -1; dy <= 1; dy++) begin
      for (int dx = -1; dx <= 1; dx++) begin
        // Neighbor coordinates wrap within 32 bits before sign extension.
        cx = x + 32'(dx);
        cy = y + 32'(dy);
        h = (64'(cx) * 64'sd374761393) ^ (64'(cy) * 64'sd668265263)
            ^ {32'd0, model_seed};
        cell_type[k] = residue5(h);
        cell_mag[k] = residue5(h >>> 8) + 1;
        // Type codes 0 and 1 swap matrix rows.
        cell_row[k] = (cell_type[k] < 2) ? (cell_type[k] ^ 1) : cell_type[k];
        k++;
      end
    end
    for (int i = 0; i < 9; i++) begin
      for (int j = i + 1; j < 9; j++) begin
        d = int'(cell_mag[i]) - int'(cell_mag[j]);
        if (d < 0) d = -d;
        sum += interaction_quarters(cell_row[i], cell_row[j]) + d;
      end
    end
    if (model_normalize) begin
      q = floor_quot(512 * (sum + 216) + 81, 162);
      if (q < 0) q = 0;
      if (q > 4096) q = 4096;
    end else begin
      q = floor_quot(512 * sum + 9, 18);
    end
    r.pair_sum = 11'(sum);
    r.intensity = 16'(q);
    r.ctype = 3'(cell_type[4]);
    r.cmag = 3'(cell_mag[4]);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  // Writes one register; the trailing edge keeps back-to-back writes apart.
  task automatic write_register(input logic [1:0] index, input logic [31:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (index == CFG_SEED) model_seed = value;
    else if (index == CFG_MODE) model_normalize = value[0];
    @(posedge clk_i);
  endtask

  // Offers one coordinate after a random gap, unless no_gaps is set, and waits for acceptance.
  // Valid stays high after acceptance; a gap or a drain lowers it.
  task automatic send_coord(input logic signed [31:0] x, input logic signed [31:0] y,
                            input bit no_gaps);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    coord_x_i <= x;
    coord_y_i <= y;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops sending and waits until every expected result has arrived.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (NUM_STG + 3) @(posedge clk_i);
  endtask

  // Receiver: random stall per result, with stall-free stretches.
  initial begin
    int unsigned stall;
    bit eager;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      eager = ($urandom_range(0, 7) == 0);
      repeat (40) begin
        stall = eager ? 0 : $urandom_range(0, 18);
        if (stall != 0) begin
          out_ready_i <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        out_ready_i <= 1'b1;
        do @(posedge clk_i); while (!out_valid_o);
      end
    end
  end

  // Scoreboard: sample accepted results at the clock edge.
  always @(posedge clk_i) begin
    field_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_results.pop_front();
        if (pair_sum_quarters_o !== want.pair_sum)
          report_mismatch("pair_sum_quarters", pair_sum_quarters_o, want.pair_sum);
        if (intensity_q12_o !== want.intensity)
          report_mismatch("intensity_q12", intensity_q12_o, want.intensity);
        if (centre_type_o !== want.ctype)
          report_mismatch("centre_type", centre_type_o, want.ctype);
        if (centre_magnitude_o !== want.cmag)
          report_mismatch("centre_magnitude", centre_magnitude_o, want.cmag);
      end
    end
  end

  // Queue the expectation when the input item is accepted.
  always @(posedge clk_i) begin
    field_result_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      r = field_at(coord_x_i, coord_y_i);
      expected_results.insert(expected_results.size(), r);
    end
  end

  // Safety limit.
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

  // Main stimulus.
  initial begin
    directed_row_t table_rows[10];
    directed_row_t row;
    field_result_t anchor;
    logic signed [31:0] bx;
    logic signed [31:0] by;
    logic [31:0] seeds[5];
    int unsigned n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    coord_x_i = '0;
    coord_y_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_SEED;
    cfg_data_i = '0;
    model_seed = '0;
    model_normalize = 1'b0;
    mismatch_count = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part. At the origin the centre hash is the seed itself; for
    // seed zero and for all ones it is a multiple of 5, as is the hash
    // shifted by 8, so the centre is type 0 with magnitude 1. The rest is
    // checked by the predictor.
    table_rows[0] = '{32'sd0, 32'sd0, 1'b1, '{11'sd0, 16'sd0, 3'd0, 3'd1}};
    table_rows[1] = '{32'h7fffffff, 32'h7fffffff, 1'b0, '0};
    table_rows[2] = '{32'h80000000, 32'h80000000, 1'b0, '0};
    table_rows[3] = '{32'h7fffffff, 32'h80000000, 1'b0, '0};
    table_rows[4] = '{32'h80000000, 32'h7fffffff, 1'b0, '0};
    table_rows[5] = '{-32'sd1, -32'sd1, 1'b0, '0};
    table_rows[6] = '{32'sd1, -32'sd1, 1'b0, '0};
    table_rows[7] = '{32'hffffffff, 32'sd0, 1'b0, '0};
    table_rows[8] = '{32'sd12345, -32'sd777, 1'b0, '0};
    table_rows[9] = '{32'h55555555, 32'haaaaaaaa, 1'b0, '0};

    seeds = '{32'd0, 32'hffffffff, 32'h80000000, 32'd1, 32'h1234abcd};
    for (int m = 0; m < 2; m++) begin
      write_register(CFG_MODE, 32'(m));
      for (int s = 0; s < 2; s++) begin
        write_register(CFG_SEED, seeds[s]);
        foreach (table_rows[i]) begin
          row = table_rows[i];
          if (row.has_expected) begin
            anchor = field_at(row.x, row.y);
            if (anchor.ctype !== row.expected.ctype)
              report_mismatch("directed centre_type", anchor.ctype, row.expected.ctype);
            if (anchor.cmag !== row.expected.cmag)
              report_mismatch("directed centre_magnitude", anchor.cmag, row.expected.cmag);
          end
          send_coord(row.x, row.y, 1'b0);
        end
        drain();
      end
    end
    // Centre item: seed zero, the origin gives centre type 0 and
    // magnitude 1.
    write_register(CFG_SEED, 32'd0);
    write_register(CFG_MODE, 32'd0);
    send_coord(32'sd0, 32'sd0, 1'b0);
    drain();

    // Random part: phases with different settings, mixing raster runs
    // (consecutive coordinates, as a sweep would give) with random points.
    for (int phase = 0; phase < 8; phase++) begin
      write_register(CFG_SEED, (phase < 5) ? seeds[phase] : $urandom());
      write_register(CFG_MODE, 32'($urandom_range(0, 1)));
      n = 0;
      while (n < 215) begin
        if ($urandom_range(0, 2) == 0) begin
          send_coord($urandom(), $urandom(), 1'b0);
          n++;
        end else begin
          bx = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 64)) - 32;
          by = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 64)) - 32;
          for (int k = 0; k < 8; k++) begin
            send_coord(bx + 32'(k), by, phase[0] && k > 2);
            n++;
          end
        end
        // Hold the sender until everything is out, at least once a phase.
        if (n > 100 && n < 110) drain();
      end
      drain();
    end

    drain();
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
